/* sv/plt_pkg.sv */
`timescale 1ns / 1ps
package plt_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W     = 5;
   localparam int CH_W       = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE = 2'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_MAP  = 1'b1;

   // operand channel selects: scale first, then colour
   localparam logic [CH_W-1:0] CH_SCALE = 3'd0;
   localparam logic [CH_W-1:0] CH_R     = 3'd1;
   localparam logic [CH_W-1:0] CH_G     = 3'd2;
   localparam logic [CH_W-1:0] CH_B     = 3'd3;
   localparam logic [CH_W-1:0] CH_A     = 3'd4;

   typedef struct packed {
      logic               opcode;
      logic [3:0]         node_index;
      logic signed [15:0] position;
      logic [15:0]        node_scale;
      logic [15:0]        chan_r;
      logic [15:0]        chan_g;
      logic [15:0]        chan_b;
      logic [15:0]        chan_a;
   } req_payload_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] out_r;
      logic [15:0] out_g;
      logic [15:0] out_b;
      logic [15:0] out_a;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [15:0] pos;
      logic [15:0]        scale;
      logic [15:0]        r;
      logic [15:0]        g;
      logic [15:0]        b;
      logic [15:0]        a;
   } node_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_DECIDE,
      ST_DIV,
      ST_MAC,
      ST_ALPHA,
      ST_ALPHA_SAT,
      ST_PUB
   } state_type;

   typedef enum logic [2:0] {
      MAC_NONE,
      MAC_F0,
      MAC_F1,
      MAC_SUM,
      MAC_SCALE,
      MAC_SAT,
      MAC_ALPHA,
      MAC_ALPHA_SAT
   } mac_op_type;

   typedef struct packed {
      logic            load;
      logic            start;
      logic            fetch;
      logic            advance;
      logic            set_hit;
      logic            clr_hit;
      logic            div_init;
      logic            div_step;
      logic            set_exact;
      mac_op_type      mac_op;
      logic [CH_W-1:0] mac_ch;
      logic            publish;
   } cmd_type;

   typedef struct packed {
      logic j_zero;
      logic j_lt_n;
      logic ge;
      logic eq_last;
      logic out_free;
   } status_type;

   function automatic logic [15:0] sat16(input logic signed [35:0] x);
      logic [15:0] r;
      if (x < 0) r = 16'd0;
      else if (x > 36'sd65535) r = 16'hFFFF;
      else r = x[15:0];
      return r;
   endfunction

endpackage

/* sv/plt_ctrl.sv */
`timescale 1ns / 1ps
module plt_ctrl import plt_pkg::*; #(
   parameter int COLOR_FRAC_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_is_map,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [CH_W-1:0]       chan_ff, chan_in;
   logic                  div_last;
   logic                  mac_last;
   logic                  chan_last;

   assign div_last  = (step_ff == STEP_W'(COLOR_FRAC_BITS));
   assign mac_last  = (chan_ff == CH_SCALE) ? (step_ff == 5'd2) : (step_ff == 5'd4);
   assign chan_last = (chan_ff == CH_A) && mac_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         chan_ff  <= CH_SCALE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid && req_is_map) state_in = ST_FETCH;
         ST_FETCH:     state_in = status.j_lt_n ? ST_CHECK : ST_DECIDE;
         ST_CHECK:     state_in = status.ge ? ST_FETCH : ST_DECIDE;
         ST_DECIDE: begin
            priority if (status.j_zero) state_in = ST_PUB;
            else if (status.j_lt_n)     state_in = ST_DIV;
            else if (status.eq_last)    state_in = ST_MAC;
            else                        state_in = ST_PUB;
         end
         ST_DIV:       if (div_last) state_in = ST_MAC;
         ST_MAC:       if (chan_last) state_in = ST_ALPHA;
         ST_ALPHA:     state_in = ST_ALPHA_SAT;
         ST_ALPHA_SAT: state_in = ST_PUB;
         ST_PUB:       if (status.out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // step and channel counters
   always_comb begin
      step_in = step_ff;
      chan_in = chan_ff;
      unique case (state_ff)
         ST_DECIDE: begin
            step_in = '0;
            chan_in = CH_SCALE;
         end
         ST_DIV: step_in = div_last ? '0 : step_ff + 1'b1;
         ST_MAC: begin
            if (mac_last) begin
               step_in = '0;
               chan_in = chan_ff + 1'b1;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load  = req_valid && !req_is_map;
            cmd.start = req_valid && req_is_map;
         end
         ST_FETCH: cmd.fetch = status.j_lt_n;
         ST_CHECK: cmd.advance = status.ge;
         ST_DECIDE: begin
            priority if (status.j_zero) cmd.clr_hit = 1'b1;
            else if (status.j_lt_n) begin
               cmd.set_hit  = 1'b1;
               cmd.div_init = 1'b1;
            end else if (status.eq_last) begin
               cmd.set_hit   = 1'b1;
               cmd.set_exact = 1'b1;
            end else cmd.clr_hit = 1'b1;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_MAC: begin
            cmd.mac_ch = chan_ff;
            unique case (step_ff)
               5'd0:    cmd.mac_op = MAC_F0;
               5'd1:    cmd.mac_op = MAC_F1;
               5'd2:    cmd.mac_op = MAC_SUM;
               5'd3:    cmd.mac_op = MAC_SCALE;
               5'd4:    cmd.mac_op = MAC_SAT;
               default: cmd.mac_op = MAC_NONE;
            endcase
         end
         ST_ALPHA:     cmd.mac_op = MAC_ALPHA;
         ST_ALPHA_SAT: cmd.mac_op = MAC_ALPHA_SAT;
         ST_PUB:       cmd.publish = status.out_free;
         default: ;
      endcase
   end

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff <= STEP_W'(COLOR_FRAC_BITS)))
      else $error("divider ran past its last quotient bit");

   a_pub_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> (state_ff == ST_IDLE))
      else $error("no return to idle after publishing");

   a_mac_chan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (chan_ff <= CH_A))
      else $error("channel counter out of range");

endmodule

/* sv/plt_dp.sv */
`timescale 1ns / 1ps
module plt_dp import plt_pkg::*; #(
   parameter int MAX_NODES       = 16,
   parameter int COLOR_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  req_payload_type       req_payload,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int F     = COLOR_FRAC_BITS;
   localparam int FW    = COLOR_FRAC_BITS + 1;
   localparam logic [FW-1:0]        ONE_F  = FW'(1) << F;
   localparam logic [17:0]          ONE_W  = 18'd1 << F;
   localparam logic signed [35:0]   HALF_P = 36'sd1 <<< (F - 1);

   node_type mem [MAX_NODES];
   node_type rd_ff;

   req_payload_type    item_ff, item_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   node_type           prev_ff, prev_in;
   logic [15:0]        den_ff, den_in;
   logic [16:0]        rem_ff, rem_in;
   logic [FW-1:0]      f0_ff, f0_in;
   logic signed [35:0] prod_ff, prod_in;
   logic signed [35:0] acc_ff, acc_in;
   logic [15:0]        sc_ff, sc_in;
   logic [15:0]        it_ff, it_in;
   logic [15:0]        col_ff [4];
   logic [15:0]        col_in [4];
   logic [15:0]        alpha_ff, alpha_in;
   logic               hit_ff, hit_in;
   rsp_payload_type    out_ff, out_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [4:0]         node_count_ff, node_count_in;
   logic               blend_ff, blend_in;

   logic                wr_ok;
   logic [IDX_W-1:0]    wr_addr;
   node_type            wr_node;
   logic [CNT_W-1:0]    n_eff;
   logic signed [16:0]  num_s;
   logic signed [16:0]  den_s;
   logic                q_bit;
   logic [16:0]         rem_sub;
   logic [FW-1:0]       f1;
   logic [15:0]         a_val, b_val;
   logic [17:0]         mul_a, mul_b;
   logic signed [35:0]  mul_p;
   logic signed [35:0]  sum_p;
   logic signed [35:0]  rnd_q;
   logic [1:0]          col_idx;
   rsp_payload_type     result;
   logic [16:0]         bl_r, bl_g, bl_b;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = out_ff;

   assign wr_ok   = ({28'd0, req_payload.node_index} < 32'(MAX_NODES));
   assign wr_addr = IDX_W'(req_payload.node_index);
   assign wr_node = '{pos: req_payload.position, scale: req_payload.node_scale,
                      r: req_payload.chan_r, g: req_payload.chan_g,
                      b: req_payload.chan_b, a: req_payload.chan_a};

   // node table: one write port on load, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) mem[wr_addr] <= wr_node;
      if (cmd.fetch) rd_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

   assign n_eff = (32'(node_count_ff) > MAX_NODES) ? CNT_W'(MAX_NODES)
                                                   : CNT_W'(node_count_ff);

   assign status.j_zero   = (cnt_ff == '0);
   assign status.j_lt_n   = (cnt_ff < n_eff);
   assign status.ge       = (item_ff.position >= rd_ff.pos);
   assign status.eq_last  = (item_ff.position == prev_ff.pos);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // restoring division: f0 = floor(num * ONE / den), num never above den
   assign num_s   = {rd_ff.pos[15], rd_ff.pos} - {item_ff.position[15], item_ff.position};
   assign den_s   = {rd_ff.pos[15], rd_ff.pos} - {prev_ff.pos[15], prev_ff.pos};
   assign q_bit   = (rem_ff >= {1'b0, den_ff});
   assign rem_sub = q_bit ? rem_ff - {1'b0, den_ff} : rem_ff;
   assign f1      = ONE_F - f0_ff;

   always_comb begin
      unique case (cmd.mac_ch)
         CH_SCALE: begin a_val = prev_ff.scale; b_val = rd_ff.scale; end
         CH_R:     begin a_val = prev_ff.r;     b_val = rd_ff.r;     end
         CH_G:     begin a_val = prev_ff.g;     b_val = rd_ff.g;     end
         CH_B:     begin a_val = prev_ff.b;     b_val = rd_ff.b;     end
         CH_A:     begin a_val = prev_ff.a;     b_val = rd_ff.a;     end
         default:  begin a_val = '0;            b_val = '0;          end
      endcase
   end

   // the one shared multiplier
   always_comb begin
      unique case (cmd.mac_op)
         MAC_F0: begin
            mul_a = 18'(f0_ff);
            mul_b = {2'b00, a_val};
         end
         MAC_F1: begin
            mul_a = 18'(f1);
            mul_b = {2'b00, b_val};
         end
         MAC_SCALE: begin
            mul_a = {2'b00, sc_ff};
            mul_b = {2'b00, it_ff};
         end
         MAC_ALPHA: begin
            mul_a = ONE_W - {2'b00, col_ff[3]};
            mul_b = ONE_W - {2'b00, item_ff.chan_a};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = $signed(mul_a) * $signed(mul_b);
   assign sum_p   = acc_ff + prod_ff + HALF_P;
   assign rnd_q   = (prod_ff + HALF_P) >>> F;
   assign col_idx = 2'(cmd.mac_ch - 3'd1);

   assign bl_r = {1'b0, item_ff.chan_r} + {1'b0, col_ff[0]};
   assign bl_g = {1'b0, item_ff.chan_g} + {1'b0, col_ff[1]};
   assign bl_b = {1'b0, item_ff.chan_b} + {1'b0, col_ff[2]};

   always_comb begin
      result.hit = hit_ff;
      if (!hit_ff) begin
         result.out_r = item_ff.chan_r;
         result.out_g = item_ff.chan_g;
         result.out_b = item_ff.chan_b;
         result.out_a = item_ff.chan_a;
      end else if (blend_ff) begin
         result.out_r = bl_r[16] ? 16'hFFFF : bl_r[15:0];
         result.out_g = bl_g[16] ? 16'hFFFF : bl_g[15:0];
         result.out_b = bl_b[16] ? 16'hFFFF : bl_b[15:0];
         result.out_a = alpha_ff;
      end else begin
         result.out_r = col_ff[0];
         result.out_g = col_ff[1];
         result.out_b = col_ff[2];
         result.out_a = col_ff[3];
      end
   end

   always_comb begin
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      prev_in       = prev_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      f0_in         = f0_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      sc_in         = sc_ff;
      it_in         = it_ff;
      col_in        = col_ff;
      alpha_in      = alpha_ff;
      hit_in        = hit_ff;
      out_in        = out_ff;
      rsp_valid_in  = rsp_valid_ff;
      node_count_in = node_count_ff;
      blend_in      = blend_ff;

      if (cmd.start) begin
         item_in = req_payload;
         cnt_in  = '0;
      end
      if (cmd.advance) begin
         prev_in = rd_ff;
         cnt_in  = cnt_ff + 1'b1;
      end
      if (cmd.set_hit) hit_in = 1'b1;
      if (cmd.clr_hit) hit_in = 1'b0;
      if (cmd.div_init) begin
         rem_in = {1'b0, num_s[15:0]};
         den_in = den_s[15:0];
         f0_in  = '0;
      end
      if (cmd.set_exact) f0_in = ONE_F;
      if (cmd.div_step) begin
         rem_in = {rem_sub[15:0], 1'b0};
         f0_in  = {f0_ff[FW-2:0], q_bit};
      end

      unique case (cmd.mac_op)
         MAC_F0:    prod_in = mul_p;
         MAC_F1: begin
            acc_in  = prod_ff;
            prod_in = mul_p;
         end
         MAC_SUM: begin
            if (cmd.mac_ch == CH_SCALE) sc_in = sum_p[F+15:F];
            else it_in = sum_p[F+15:F];
         end
         MAC_SCALE:     prod_in = mul_p;
         MAC_SAT:       col_in[col_idx] = sat16(rnd_q);
         MAC_ALPHA:     prod_in = mul_p;
         MAC_ALPHA_SAT: alpha_in = sat16($signed(36'(ONE_W)) - rnd_q);
         default: ;
      endcase

      if (csr_valid) begin
         if (csr_index == CSR_NODE_COUNT) node_count_in = csr_data[4:0];
         else if (csr_index == CSR_BLEND_MODE) blend_in = csr_data[0];
      end

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         out_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= '0;
         blend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         node_count_ff <= node_count_in;
         blend_ff      <= blend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      cnt_ff   <= cnt_in;
      prev_ff  <= prev_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      f0_ff    <= f0_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      sc_ff    <= sc_in;
      it_ff    <= it_in;
      col_ff   <= col_in;
      alpha_ff <= alpha_in;
      hit_ff   <= hit_in;
      out_ff   <= out_in;
   end

   a_pub_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten while the output beat waits");

   a_f0_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mac_op == MAC_F0) |-> (f0_ff <= ONE_F))
      else $error("interpolation weight above one");

   a_fetch_range: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (cnt_ff < n_eff))
      else $error("node read beyond the nodes in use");

endmodule

/* sv/piecewise_linear_transfer_rgba.sv */
`timescale 1ns / 1ps
// Piecewise-linear transfer function, RGBA out.
// Channels: req_ carries one item per beat. A load beat (opcode 0) writes one
// node and is done in its accept cycle. A map beat (opcode 1) gives exactly
// one rsp_ beat carrying hit and the resulting colour. csr_ writes node_count
// (index 0) or blend_mode (index 1); csr_ready is always high. Write the csr
// registers only while no map item is in flight.
// A map item, accept to rsp_valid: for each node compared a registered node
// table read, then a compare; the decision state; then on an interior hit the
// restoring divider (COLOR_FRAC_BITS+1 quotient bits), and on any hit the
// single shared multiplier (five interpolations, four scale products, one
// alpha product); then the publish state. The block takes one map item at a
// time; req_ready is high only when the controller is idle.
// Reset clears the controller, the output valid and both csr registers. The
// node table is not cleared: load every node in use before mapping.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and runs up to its publish step, where it waits.
module piecewise_linear_transfer_rgba import plt_pkg::*; #(
   parameter int MAX_NODES       = 16,
   parameter int COLOR_FRAC_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: scan, divide, multiply steps, publish
   plt_ctrl #(
      .COLOR_FRAC_BITS(COLOR_FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_is_map (req_payload.opcode == OP_MAP),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // node table, divider, shared multiplier, csr and output registers
   plt_dp #(
      .MAX_NODES      (MAX_NODES),
      .COLOR_FRAC_BITS(COLOR_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* tb/tb_piecewise_linear_transfer_rgba.sv */
`timescale 1ns / 1ps
module tb_piecewise_linear_transfer_rgba;
   import plt_pkg::*;

   localparam int NODES      = 16;
   localparam int FRAC       = 12;
   localparam longint ONE    = 64'sd1 << FRAC;
   localparam longint HALF   = 64'sd1 << (FRAC - 1);
   // settle time after draining; leave a margin over the longest map item
   localparam int SETTLE     = 120;
   localparam int STALL_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state: its own copy of the table and the registers
   node_type        shadow_nodes [NODES];
   logic [4:0]      shadow_count = '0;
   logic            shadow_blend = 1'b0;
   rsp_payload_type colour_queue [$];

   int  fail_count = 0;
   int  quiet_cycles = 0;
   bit  calm = 1'b0;          // set for the final stretch: no idling on either side

   always #5 clock = ~clock;

   piecewise_linear_transfer_rgba u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   function automatic logic [15:0] clamp16(input longint x);
      if (x < 0) return 16'd0;
      if (x > 65535) return 16'hFFFF;
      return x[15:0];
   endfunction

   function automatic longint blend_lerp(input longint f0, input longint f1,
                                         input logic [15:0] lo, input logic [15:0] hi);
      return (f0 * longint'(lo) + f1 * longint'(hi) + HALF) >>> FRAC;
   endfunction

   function automatic logic [15:0] scaled(input longint s, input longint c);
      return clamp16((s * c + HALF) >>> FRAC);
   endfunction

   // Work out the colour one map beat should produce.
   function automatic rsp_payload_type map_colour(input req_payload_type item);
      rsp_payload_type res;
      logic [15:0]     col [4];
      logic [15:0]     prev [4];
      logic [15:0]     lo [4];
      logic [15:0]     hi [4];
      int              n;
      int              j;
      int              v;
      longint          f0;
      longint          f1;
      longint          sc;
      longint          prod;
      bit              hit;
      prev = '{item.chan_r, item.chan_g, item.chan_b, item.chan_a};
      v    = int'(item.position);
      n    = (shadow_count > NODES) ? NODES : int'(shadow_count);
      hit  = 1'b0;
      j    = 0;
      while (j < n && v >= int'(shadow_nodes[j].pos)) j++;
      if (j > 0 && j < n) begin
         node_type a = shadow_nodes[j-1];
         node_type b = shadow_nodes[j];
         f0 = ((longint'(b.pos) - v) * ONE) / (longint'(b.pos) - longint'(a.pos));
         f1 = ONE - f0;
         lo = '{a.r, a.g, a.b, a.a};
         hi = '{b.r, b.g, b.b, b.a};
         sc = blend_lerp(f0, f1, a.scale, b.scale);
         for (int k = 0; k < 4; k++) col[k] = scaled(sc, blend_lerp(f0, f1, lo[k], hi[k]));
         hit = 1'b1;
      end else if (j > 0 && j == n && v == int'(shadow_nodes[j-1].pos)) begin
         node_type a = shadow_nodes[j-1];
         lo = '{a.r, a.g, a.b, a.a};
         for (int k = 0; k < 4; k++) col[k] = scaled(a.scale, lo[k]);
         hit = 1'b1;
      end
      res.hit = hit;
      if (!hit) begin
         col = prev;
      end else if (shadow_blend) begin
         for (int k = 0; k < 3; k++) col[k] = clamp16(longint'(prev[k]) + col[k]);
         prod   = (ONE - longint'(col[3])) * (ONE - longint'(prev[3]));
         // arithmetic shift floors negative products as well
         col[3] = clamp16(ONE - ((prod + HALF) >>> FRAC));
      end
      res.out_r = col[0];
      res.out_g = col[1];
      res.out_b = col[2];
      res.out_a = col[3];
      return res;
   endfunction

   // Send one beat, hold it until accepted, then optionally drop valid for a gap.
   task automatic send_beat(input req_payload_type item);
      int gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.opcode == OP_LOAD) shadow_nodes[item.node_index] = '{item.position,
         item.node_scale, item.chan_r, item.chan_g, item.chan_b, item.chan_a};
      else colour_queue.push_back(map_colour(item));
      if (!calm && $urandom_range(0, 2) == 0) begin
         gap = $urandom_range(1, 18);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_node(input int idx, input logic [15:0] pos, input logic [15:0] sc,
                            input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b, input logic [15:0] a);
      req_payload_type item;
      item = '{OP_LOAD, idx[3:0], pos, sc, r, g, b, a};
      send_beat(item);
   endtask

   task automatic map_sample(input logic [15:0] v, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b,
                             input logic [15:0] a);
      req_payload_type item;
      item = '{OP_MAP, 4'($urandom), v, 16'($urandom), r, g, b, a};
      send_beat(item);
   endtask

   // Drop valid, drain every expected result, then let the block settle.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (colour_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_NODE_COUNT) shadow_count = data[4:0];
      else if (idx == CSR_BLEND_MODE) shadow_blend = data[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_mode(input int count, input bit blend);
      drain();
      write_csr(CSR_NODE_COUNT, 16'(count));
      write_csr(CSR_BLEND_MODE, 16'(blend));
   endtask

   // Load a sorted table with random content so most samples land inside.
   task automatic load_sorted_table;
      int pos;
      pos = -32768 + $urandom_range(0, 3000);
      for (int i = 0; i < NODES; i++) begin
         load_node(i, 16'(pos), 16'($urandom_range(0, 8192)), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom_range(0, 8192)));
         pos += $urandom_range(1, 4000);
         if (pos > 32767) pos = 32767;
      end
   endtask

   // With an empty table every sample misses, even unwritten nodes are not read.
   task automatic test_empty_table;
      map_sample(16'h8000, 16'h0000, 16'hFFFF, 16'h1234, 16'h0FFF);
      map_sample(16'h7FFF, 16'hFFFF, 16'h0000, 16'hABCD, 16'h1000);
      map_sample(16'h0000, 16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF);
   endtask

   // Evenly spaced nodes from -30000 to 30000, with one saturating node.
   task automatic test_node_load;
      for (int i = 0; i < NODES; i++)
         load_node(i, 16'(-30000 + i * 4000), (i == 7) ? 16'hFFFF : 16'(i * 512),
                   (i == 7) ? 16'hFFFF : 16'(i * 4096), 16'(65535 - i * 4096),
                   16'(i * 256), (i == 0) ? 16'h0000 : 16'(4096 - i * 200));
   endtask

   task automatic test_map_directed;
      map_sample(16'h8000, 16'h1111, 16'h2222, 16'h3333, 16'h4444);  // below the first
      map_sample(16'(-30000), 16'h0, 16'h0, 16'h0, 16'h0);           // on the first
      map_sample(16'(-27999), 16'h0, 16'h0, 16'h0, 16'h0);           // between
      map_sample(16'(-2001), 16'hFFFF, 16'h0, 16'h0, 16'hFFFF);      // next to saturation
      map_sample(16'(-2000), 16'h0, 16'h0, 16'h0, 16'h0);            // saturating node
      map_sample(16'd29999, 16'h0, 16'h0, 16'h0, 16'h0);
      map_sample(16'd30000, 16'h0, 16'h0, 16'h0, 16'h0);             // exactly the last
      map_sample(16'd30001, 16'hBEEF, 16'h0, 16'hFFFF, 16'h1);       // just beyond the last
      map_sample(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_blend_directed;
      set_mode(NODES, 1'b1);
      map_sample(16'(-2000), 16'hFFFF, 16'h8000, 16'h0, 16'h0);
      map_sample(16'(-10001), 16'h0, 16'h0, 16'h0, 16'hFFFF);
      map_sample(16'd30000, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
      map_sample(16'h8000, 16'h1, 16'h2, 16'h3, 16'h4);
   endtask

   // One node in use: only its exact position hits. A count above the
   // table size behaves as a full table.
   task automatic test_count_edges;
      set_mode(1, 1'b0);
      map_sample(16'(-30000), 16'h0, 16'h0, 16'h0, 16'h0);
      map_sample(16'(-29999), 16'h7, 16'h7, 16'h7, 16'h7);
      set_mode(31, 1'b0);
      map_sample(16'd30000, 16'h0, 16'h0, 16'h0, 16'h0);
      map_sample(16'd1234, 16'h0, 16'h0, 16'h0, 16'h0);
   endtask

   task automatic test_random_phases;
      int              pos;
      int              k;
      req_payload_type item;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 4) begin
            set_mode(NODES, $urandom_range(0, 1));
            calm = 1'b1;
         end else begin
            set_mode((phase == 0) ? 0 : $urandom_range(0, 31), phase[0]);
         end
         load_sorted_table();
         for (int i = 0; i < 130; i++) begin
            item = req_payload_type'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 9) < 8) begin
               item.opcode = OP_MAP;
               k = $urandom_range(0, NODES - 1);
               case ($urandom_range(0, 3))
                  0: ;                                 // fully random sample
                  1: item.position = shadow_nodes[k].pos;
                  default: begin
                     pos = int'(shadow_nodes[k].pos) + $urandom_range(0, 600) - 300;
                     item.position = 16'(pos);
                  end
               endcase
            end else begin
               item.opcode = OP_LOAD;                 // noise: may unsort the table
            end
            send_beat(item);
         end
      end
   endtask

   // Result side: random ready bursts, field-by-field check against the oldest
   // expectation.
   int ready_hold = 0;
   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (colour_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               fail_count++;
            end else begin
               want = colour_queue.pop_front();
               if (rsp_payload.hit !== want.hit) begin
                  $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_payload.hit);
                  fail_count++;
               end
               if (rsp_payload.out_r !== want.out_r) begin
                  $display("%0t: out_r expected %h actual %h", $time, want.out_r,
                           rsp_payload.out_r);
                  fail_count++;
               end
               if (rsp_payload.out_g !== want.out_g) begin
                  $display("%0t: out_g expected %h actual %h", $time, want.out_g,
                           rsp_payload.out_g);
                  fail_count++;
               end
               if (rsp_payload.out_b !== want.out_b) begin
                  $display("%0t: out_b expected %h actual %h", $time, want.out_b,
                           rsp_payload.out_b);
                  fail_count++;
               end
               if (rsp_payload.out_a !== want.out_a) begin
                  $display("%0t: out_a expected %h actual %h", $time, want.out_a,
                           rsp_payload.out_a);
                  fail_count++;
               end
            end
         end
         // advance the ready pattern: bursts of stall or flow
         if (calm) begin
            rsp_ready <= 1'b1;
         end else if (ready_hold == 0) begin
            rsp_ready  <= $urandom_range(0, 1);
            ready_hold <= $urandom_range(1, 18);
         end else begin
            ready_hold <= ready_hold - 1;
         end
      end
   end

   // Watchdog: count cycles with no beat on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_table();
      test_node_load();
      set_mode(NODES, 1'b0);
      test_map_directed();
      test_blend_directed();
      test_count_edges();
      test_random_phases();
      drain();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* piecewise_linear_transfer_rgba.f */
sv/plt_pkg.sv
sv/plt_ctrl.sv
sv/plt_dp.sv
sv/piecewise_linear_transfer_rgba.sv
tb/tb_piecewise_linear_transfer_rgba.sv
